FILE: rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg: calendar day stepper shared definitions
// Field widths, reset values, register indexes, status codes and the
// month length table.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int DAY_BITS      = 5;
    localparam int MONTH_BITS    = 4;
    localparam int YEAR_BITS     = 12;
    localparam int WDAY_BITS     = 3;
    localparam int STATUS_BITS   = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam int ELAPSED_BITS_DEF = 17;

    localparam logic [MONTH_BITS-1:0] MONTHS_PER_YEAR = MONTH_BITS'(12);
    localparam logic [DAY_BITS-1:0]   LEN_LONG        = DAY_BITS'(31);
    localparam logic [DAY_BITS-1:0]   LEN_SHORT       = DAY_BITS'(30);
    localparam logic [DAY_BITS-1:0]   LEN_FEB         = DAY_BITS'(28);
    localparam logic [DAY_BITS-1:0]   LEN_FEB_LEAP    = DAY_BITS'(29);

    localparam logic [YEAR_BITS-1:0] RST_YEAR    = YEAR_BITS'(1980);
    localparam logic [WDAY_BITS-1:0] RST_WEEKDAY = WDAY_BITS'(1);
    localparam logic [WDAY_BITS-1:0] WDAY_LAST   = WDAY_BITS'(6);
    localparam logic [WDAY_BITS-1:0] WDAY_OVER   = WDAY_BITS'(7);

    typedef enum logic [STATUS_BITS-1:0] {
        ST_RUNNING = 2'd0,
        ST_REACHED = 2'd1,
        ST_PASSED  = 2'd2,
        ST_IDLE    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_DAY     = 3'd0,
        CFG_START_MONTH   = 3'd1,
        CFG_START_YEAR    = 3'd2,
        CFG_START_WEEKDAY = 3'd3,
        CFG_TARGET_DAY    = 3'd4,
        CFG_TARGET_MONTH  = 3'd5,
        CFG_TARGET_YEAR   = 3'd6
    } t_cfg_idx;

    // zero for month codes 12..15; leap rule is year divisible by 4
    function automatic logic [DAY_BITS-1:0] month_len(
        input logic [MONTH_BITS-1:0] month,
        input logic [YEAR_BITS-1:0]  year
    );
        logic [DAY_BITS-1:0] len;
        case (month) inside
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = LEN_LONG;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = LEN_SHORT;
            4'd1:    len = (year[1:0] == 2'b00) ? LEN_FEB_LEAP : LEN_FEB;
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/cds_if.sv
// ----------------------------------------------------------------------------
// cds_if: calendar day stepper channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface cds_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface cds_out_if
    import cds_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [WDAY_BITS-1:0]    weekday;
    logic [DAY_BITS-1:0]     day_of_month;
    logic [MONTH_BITS-1:0]   month_of_year;
    logic [YEAR_BITS-1:0]    year_now;
    logic [ELAPSED_BITS-1:0] elapsed_days;
    logic [STATUS_BITS-1:0]  status;

    modport source (
        output valid, output weekday, output day_of_month, output month_of_year,
        output year_now, output elapsed_days, output status, input ready
    );
    modport sink (
        input valid, input weekday, input day_of_month, input month_of_year,
        input year_now, input elapsed_days, input status, output ready
    );
endinterface

interface cds_cfg_if
    import cds_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/calendar_day_stepper.sv
// ----------------------------------------------------------------------------
// calendar_day_stepper: one calendar day per item towards a target date
// Date, weekday and elapsed-day counters with target compare and status.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while the output register is empty or
// being read, and its result appears in the output register on the
// following cycle; an unread result stalls the input. The counters are
// updated combinationally. A restart item reloads date and weekday
// from the start registers and clears the elapsed count; a tick item
// in a run advances one day, or spends the step normalising an out-of-range
// day or month. Running stops with status reached on a target match and
// with status passed once the year exceeds the target year. Configuration
// writes take effect on the next cycle and are always accepted; target
// changes apply to a run in progress, start values only at the next restart.
// ----------------------------------------------------------------------------
module calendar_day_stepper
    import cds_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cds_in_if.sink     i_in,
    cds_out_if.source  o_out,
    cds_cfg_if.sink    i_cfg
);

    logic [DAY_BITS-1:0]   r_start_day, r_tgt_day;
    logic [MONTH_BITS-1:0] r_start_month, r_tgt_month;
    logic [YEAR_BITS-1:0]  r_start_year, r_tgt_year;
    logic [WDAY_BITS-1:0]  r_start_wday;

    logic                    r_running, n_running;
    logic [DAY_BITS-1:0]     r_day, n_day;
    logic [MONTH_BITS-1:0]   r_month, n_month;
    logic [YEAR_BITS-1:0]    r_year, n_year;
    logic [WDAY_BITS-1:0]    r_wday, n_wday;
    logic [ELAPSED_BITS-1:0] r_elapsed, n_elapsed;
    t_status                 r_last, n_last;

    logic                    r_out_valid;
    logic [WDAY_BITS-1:0]    r_out_wday;
    logic [DAY_BITS-1:0]     r_out_day;
    logic [MONTH_BITS-1:0]   r_out_month;
    logic [YEAR_BITS-1:0]    r_out_year;
    logic [ELAPSED_BITS-1:0] r_out_elapsed;
    t_status                 r_out_status;

    logic                  in_acc;
    logic [DAY_BITS-1:0]   len;
    logic [DAY_BITS-1:0]   day_inc;
    logic [MONTH_BITS-1:0] mon_inc;
    logic                  mon_wrap;
    logic [YEAR_BITS-1:0]  year_inc;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign len      = month_len(r_month, r_year);
    assign day_inc  = r_day + DAY_BITS'(1);
    assign mon_inc  = r_month + MONTH_BITS'(1);
    assign mon_wrap = (mon_inc >= MONTHS_PER_YEAR);
    assign year_inc = r_year + YEAR_BITS'(1);

    always_comb begin
        n_running = r_running;
        n_day     = r_day;
        n_month   = r_month;
        n_year    = r_year;
        n_wday    = r_wday;
        n_elapsed = r_elapsed;
        n_last    = r_last;
        if (i_in.restart) begin
            n_day     = r_start_day;
            n_month   = r_start_month;
            n_year    = r_start_year;
            n_wday    = r_start_wday;
            n_elapsed = '0;
            n_running = 1'b1;
            n_last    = ST_RUNNING;
        end else if (r_running) begin
            if (r_year > r_tgt_year) begin
                n_running = 1'b0;
                n_last    = ST_PASSED;
            end else if (r_month >= MONTHS_PER_YEAR) begin
                n_month = '0;
                n_year  = year_inc;
            end else if (r_day >= len) begin
                n_day   = '0;
                n_month = mon_wrap ? '0 : mon_inc;
                n_year  = mon_wrap ? year_inc : r_year;
            end else if (r_year == r_tgt_year && r_month == r_tgt_month
                         && r_day == r_tgt_day) begin
                n_running = 1'b0;
                n_last    = ST_REACHED;
            end else begin
                // a loaded 7 wraps to 1
                if (r_wday == WDAY_LAST) begin
                    n_wday = '0;
                end else if (r_wday == WDAY_OVER) begin
                    n_wday = WDAY_BITS'(1);
                end else begin
                    n_wday = r_wday + WDAY_BITS'(1);
                end
                if (r_elapsed != '1) begin
                    n_elapsed = r_elapsed + ELAPSED_BITS'(1);
                end
                if (day_inc >= len) begin
                    n_day   = '0;
                    n_month = mon_wrap ? '0 : mon_inc;
                    n_year  = mon_wrap ? year_inc : r_year;
                end else begin
                    n_day = day_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_day   <= '0;
            r_start_month <= '0;
            r_start_year  <= RST_YEAR;
            r_start_wday  <= RST_WEEKDAY;
            r_tgt_day     <= '0;
            r_tgt_month   <= '0;
            r_tgt_year    <= RST_YEAR;
            r_running     <= 1'b0;
            r_day         <= '0;
            r_month       <= '0;
            r_year        <= RST_YEAR;
            r_wday        <= RST_WEEKDAY;
            r_elapsed     <= '0;
            r_last        <= ST_IDLE;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_START_DAY:     r_start_day   <= i_cfg.data[DAY_BITS-1:0];
                    CFG_START_MONTH:   r_start_month <= i_cfg.data[MONTH_BITS-1:0];
                    CFG_START_YEAR:    r_start_year  <= i_cfg.data[YEAR_BITS-1:0];
                    CFG_START_WEEKDAY: r_start_wday  <= i_cfg.data[WDAY_BITS-1:0];
                    CFG_TARGET_DAY:    r_tgt_day     <= i_cfg.data[DAY_BITS-1:0];
                    CFG_TARGET_MONTH:  r_tgt_month   <= i_cfg.data[MONTH_BITS-1:0];
                    CFG_TARGET_YEAR:   r_tgt_year    <= i_cfg.data[YEAR_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_running   <= n_running;
                r_day       <= n_day;
                r_month     <= n_month;
                r_year      <= n_year;
                r_wday      <= n_wday;
                r_elapsed   <= n_elapsed;
                r_last      <= n_last;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_wday    <= n_wday;
            r_out_day     <= n_day;
            r_out_month   <= n_month;
            r_out_year    <= n_year;
            r_out_elapsed <= n_elapsed;
            r_out_status  <= n_running ? ST_RUNNING : n_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.weekday       = r_out_wday;
    assign o_out.day_of_month  = r_out_day;
    assign o_out.month_of_year = r_out_month;
    assign o_out.year_now      = r_out_year;
    assign o_out.elapsed_days  = r_out_elapsed;
    assign o_out.status        = r_out_status;

`ifndef SYNTHESIS
    a_run_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_last == ST_RUNNING))
        else $error("running with a final outcome recorded");

    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.restart) |=> (r_running && r_elapsed == '0))
        else $error("restart did not start a fresh run");

    a_idle_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.restart && !r_running)
            |=> ($stable(r_day) && $stable(r_month) && $stable(r_year)
                 && $stable(r_wday) && $stable(r_elapsed)))
        else $error("counters moved while idle");

    a_elapsed_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.restart) |=> (r_elapsed >= $past(r_elapsed)))
        else $error("elapsed count went backwards");

    a_out_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_acc) |-> ((r_out_status == ST_RUNNING) == r_running))
        else $error("result status disagrees with run state");
`endif

endmodule

FILE: bench/calendar_day_stepper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_day_stepper_tb: self-checking bench for the calendar day stepper
// Drives restart and tick items against programmed start and target dates.
// A calendar tracker predicts every result item and checks them in order.
// Handshake stalls come in three phases: a slow receiver, then a slow
// sender, then no stalls.
// ----------------------------------------------------------------------------
module calendar_day_stepper_tb;
    import cds_pkg::*;

    localparam int ELAPSED_BITS    = ELAPSED_BITS_DEF;
    localparam int HALF_PERIOD     = 5;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int PHASE_ITEMS     = 300;
    localparam int TIMEOUT_NS      = 10_000_000;
    localparam int REPORT_LIMIT    = 10;
    localparam int DAY_CODE_MAX    = (1 << DAY_BITS) - 1;
    localparam int YEAR_CODE_MAX   = (1 << YEAR_BITS) - 1;
    localparam int MONTH_CODE_MAX  = (1 << MONTH_BITS) - 1;
    localparam int WDAY_CODE_MAX   = (1 << WDAY_BITS) - 1;
    localparam int FIRST_YEAR      = 1901;
    localparam int LAST_YEAR       = 2099;

    typedef struct packed {
        logic [WDAY_BITS-1:0]    weekday;
        logic [DAY_BITS-1:0]     day;
        logic [MONTH_BITS-1:0]   month;
        logic [YEAR_BITS-1:0]    year;
        logic [ELAPSED_BITS-1:0] elapsed;
        logic [STATUS_BITS-1:0]  status;
    } t_date_rec;

    function automatic int unsigned days_in_month(
        input logic [MONTH_BITS-1:0] m,
        input logic [YEAR_BITS-1:0]  y
    );
        if (m >= MONTHS_PER_YEAR)
            return 0;
        if (m == 4'd1)
            return (y[1:0] == 2'b00) ? LEN_FEB_LEAP : LEN_FEB;
        if (m == 4'd3 || m == 4'd5 || m == 4'd8 || m == 4'd10)
            return LEN_SHORT;
        return LEN_LONG;
    endfunction

    class t_calendar_tracker;
        logic [DAY_BITS-1:0]     start_day, goal_day, cur_day;
        logic [MONTH_BITS-1:0]   start_month, goal_month, cur_month;
        logic [YEAR_BITS-1:0]    start_year, goal_year, cur_year;
        logic [WDAY_BITS-1:0]    start_wday, cur_wday;
        logic [ELAPSED_BITS-1:0] cur_elapsed;
        bit                      active;
        t_status                 outcome;
        t_date_rec               pending[$];
        int unsigned             mismatches, compared, reached_seen, passed_seen;

        function new();
            start_day   = '0;
            start_month = '0;
            start_year  = RST_YEAR;
            start_wday  = RST_WEEKDAY;
            goal_day    = '0;
            goal_month  = '0;
            goal_year   = RST_YEAR;
            cur_day     = '0;
            cur_month   = '0;
            cur_year    = RST_YEAR;
            cur_wday    = RST_WEEKDAY;
            cur_elapsed = '0;
            active      = 1'b0;
            outcome     = ST_IDLE;
            mismatches  = 0;
            compared    = 0;
            reached_seen = 0;
            passed_seen  = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_START_DAY:     start_day   = value[DAY_BITS-1:0];
                CFG_START_MONTH:   start_month = value[MONTH_BITS-1:0];
                CFG_START_YEAR:    start_year  = value[YEAR_BITS-1:0];
                CFG_START_WEEKDAY: start_wday  = value[WDAY_BITS-1:0];
                CFG_TARGET_DAY:    goal_day    = value[DAY_BITS-1:0];
                CFG_TARGET_MONTH:  goal_month  = value[MONTH_BITS-1:0];
                CFG_TARGET_YEAR:   goal_year   = value[YEAR_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void next_month();
            cur_month = cur_month + 1'b1;
            if (cur_month >= MONTHS_PER_YEAR) begin
                cur_month = '0;
                cur_year  = cur_year + 1'b1;
            end
        endfunction

        function void advance_day(logic restart);
            int unsigned len;
            t_date_rec   want;
            if (restart) begin
                cur_day     = start_day;
                cur_month   = start_month;
                cur_year    = start_year;
                cur_wday    = start_wday;
                cur_elapsed = '0;
                active      = 1'b1;
                outcome     = ST_RUNNING;
            end else if (active) begin
                len = days_in_month(cur_month, cur_year);
                if (cur_year > goal_year) begin
                    active  = 1'b0;
                    outcome = ST_PASSED;
                end else if (cur_month >= MONTHS_PER_YEAR) begin
                    cur_month = '0;
                    cur_year  = cur_year + 1'b1;
                end else if (cur_day >= len) begin
                    cur_day = '0;
                    next_month();
                end else if (cur_year == goal_year && cur_month == goal_month &&
                             cur_day == goal_day) begin
                    active  = 1'b0;
                    outcome = ST_REACHED;
                end else begin
                    // a loaded weekday code of 7 lands on 1
                    cur_wday = WDAY_BITS'((int'(cur_wday) + 1) % (int'(WDAY_LAST) + 1));
                    if (cur_elapsed != '1)
                        cur_elapsed = cur_elapsed + 1'b1;
                    cur_day = cur_day + 1'b1;
                    if (cur_day >= len) begin
                        cur_day = '0;
                        next_month();
                    end
                end
            end
            want.weekday = cur_wday;
            want.day     = cur_day;
            want.month   = cur_month;
            want.year    = cur_year;
            want.elapsed = cur_elapsed;
            want.status  = active ? ST_RUNNING : outcome;
            pending.push_back(want);
        endfunction

        function void flag(string what, t_date_rec want, t_date_rec got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t item %0d %s: want wd=%0d d=%0d m=%0d y=%0d el=%0d st=%0d",
                         $time, compared, what, want.weekday, want.day, want.month,
                         want.year, want.elapsed, want.status,
                         "\n    got  wd=%0d d=%0d m=%0d y=%0d el=%0d st=%0d",
                         got.weekday, got.day, got.month, got.year, got.elapsed,
                         got.status);
        endfunction

        function void compare_date(t_date_rec got);
            t_date_rec want;
            compared++;
            if (got.status == ST_REACHED)
                reached_seen++;
            if (got.status == ST_PASSED)
                passed_seen++;
            if (pending.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.weekday !== want.weekday || got.day !== want.day ||
                got.month !== want.month || got.year !== want.year ||
                got.elapsed !== want.elapsed || got.status !== want.status)
                flag("mismatch", want, got);
        endfunction

        function void close_out();
            if (pending.size() != 0) begin
                mismatches += pending.size();
                $display("%0d expected results never arrived", pending.size());
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cds_in_if                                 in_ch();
    cds_out_if #(.ELAPSED_BITS(ELAPSED_BITS)) out_ch();
    cds_cfg_if                                cfg_ch();

    calendar_day_stepper #(.ELAPSED_BITS(ELAPSED_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_calendar_tracker calendar;
    t_date_rec         observed;
    int                tx_gap_pct = 15;
    int                rx_gap_pct = 85;
    int unsigned       items_sent = 0;
    int unsigned       runs_done  = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= rx_gap_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                calendar.write_reg(t_cfg_idx'(cfg_ch.index), cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                calendar.advance_day(in_ch.restart);
            if (out_ch.valid && out_ch.ready) begin
                observed = {out_ch.weekday, out_ch.day_of_month, out_ch.month_of_year,
                            out_ch.year_now, out_ch.elapsed_days, out_ch.status};
                calendar.compare_date(observed);
            end
        end
    end

    task automatic send_item(logic restart);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.restart = restart;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (calendar.pending.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = CFG_DATA_BITS'(value);
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic set_dates(int unsigned sd, int unsigned sm, int unsigned sy,
                             int unsigned sw, int unsigned td, int unsigned tm,
                             int unsigned ty);
        drain();
        write_reg(CFG_START_DAY, sd);
        write_reg(CFG_START_MONTH, sm);
        write_reg(CFG_START_YEAR, sy);
        write_reg(CFG_START_WEEKDAY, sw);
        write_reg(CFG_TARGET_DAY, td);
        write_reg(CFG_TARGET_MONTH, tm);
        write_reg(CFG_TARGET_YEAR, ty);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        runs_done++;
    endtask

    // mostly sane dates with a nearby target, some noise codes and stale targets
    task automatic random_run();
        int unsigned sd, sm, sy, sw, td, tm, ty, shape;
        shape = $urandom_range(99);
        if (shape < 85) begin
            sy = $urandom_range(LAST_YEAR, FIRST_YEAR);
            sm = $urandom_range(MONTHS_PER_YEAR - 1);
            sd = $urandom_range(days_in_month(sm, sy) - 1);
            sw = $urandom_range(WDAY_LAST);
        end else begin
            sy = $urandom_range(YEAR_CODE_MAX);
            sm = $urandom_range(MONTH_CODE_MAX);
            sd = $urandom_range(DAY_CODE_MAX);
            sw = $urandom_range(WDAY_CODE_MAX);
        end
        shape = $urandom_range(99);
        if (shape < 55) begin
            ty = sy;
            tm = sm;
            td = sd + $urandom_range(12);
            if (td > DAY_CODE_MAX)
                td = DAY_CODE_MAX;
        end else if (shape < 75) begin
            ty = sy;
            tm = sm + 1;
            td = $urandom_range(4);
            if (tm >= MONTHS_PER_YEAR) begin
                tm = 0;
                ty = (sy + 1) & YEAR_CODE_MAX;
            end
        end else if (shape < 85) begin
            ty = (sy + YEAR_CODE_MAX) & YEAR_CODE_MAX;
            tm = $urandom_range(MONTH_CODE_MAX);
            td = $urandom_range(DAY_CODE_MAX);
        end else begin
            ty = (sy + $urandom_range(1)) & YEAR_CODE_MAX;
            tm = $urandom_range(MONTH_CODE_MAX);
            td = $urandom_range(DAY_CODE_MAX);
        end
        set_dates(sd, sm, sy, sw, td, tm, ty);
        send_item(1'b1);
        repeat ($urandom_range(40, 1))
            send_item($urandom_range(99) < 4);
    endtask

    task automatic random_phase();
        int unsigned goal;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
            random_run();
    endtask

    initial begin
        calendar      = new();
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.restart = 1'b0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_START_DAY;
        cfg_ch.data   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ticks before any restart report the frozen reset date
        send_item(1'b0);
        send_item(1'b0);
        // leap February, weekday wrap, target reached then frozen
        set_dates(27, 1, 1980, WDAY_LAST, 1, 2, 1980);
        send_item(1'b1);
        repeat (5) send_item(1'b0);
        // last day of 2099 rolls into 2100 and overruns an impossible target
        set_dates(30, MONTHS_PER_YEAR - 1, LAST_YEAR, 0, 30, 1, LAST_YEAR);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        // out-of-range codes everywhere, year wraps to zero, back-to-back restart
        set_dates(DAY_CODE_MAX, MONTH_CODE_MAX, YEAR_CODE_MAX, WDAY_CODE_MAX,
                  0, 0, YEAR_CODE_MAX);
        send_item(1'b1);
        send_item(1'b1);
        repeat (4) send_item(1'b0);

        random_phase();

        drain();
        tx_gap_pct = 85;
        rx_gap_pct = 15;
        random_phase();

        drain();
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        random_phase();

        drain();
        calendar.close_out();
        $display("%0d items over %0d date programmings, %0d results checked",
                 items_sent, runs_done, calendar.compared);
        $display("%0d reached and %0d overrun results seen",
                 calendar.reached_seen, calendar.passed_seen);
        if (calendar.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", calendar.pending.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
rtl/cds_pkg.sv
rtl/cds_if.sv
rtl/calendar_day_stepper.sv
bench/calendar_day_stepper_tb.sv
